/* src/mp2_pkg.sv */
// Shared constants, register codes and types for the 2x2 max pooling block.
`timescale 1ns / 1ps
`default_nettype none
package mp2_pkg;

  localparam int DEF_MAX_CHANNELS = 64;
  localparam int DEF_MAX_WIDTH    = 256;
  localparam int DEF_MAX_HEIGHT   = 256;

  localparam int SAMPLE_W   = 16;
  localparam int CH_REG_W   = 7;
  localparam int W_REG_W    = 9;
  localparam int H_REG_W    = 9;
  localparam int CFG_DATA_W = 9;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd2;

  localparam logic [CH_REG_W-1:0] CHANNELS_RST = 7'd32;
  localparam logic [W_REG_W-1:0]  WIDTH_RST    = 9'd64;
  localparam logic [H_REG_W-1:0]  HEIGHT_RST   = 9'd64;

  // Per-sample window position decoded by the position counters
  typedef struct packed {
    logic active;   // sample lies inside a 2x2 window
    logic first;    // top-left sample of its window
    logic emit;     // bottom-right sample of its window
    logic fin;      // bottom-right sample of the final window of the frame
  } win_flags_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] pooled;
    logic                       last;
  } result_t;

endpackage
`default_nettype wire

/* src/mp2_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none
module mp2_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8192,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

/* src/mp2_ctr.sv */
// Configuration registers, frame position counters and line store address generation.
`timescale 1ns / 1ps
`default_nettype none
module mp2_ctr #(
  parameter int MAX_CHANNELS = mp2_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WIDTH    = mp2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = mp2_pkg::DEF_MAX_HEIGHT,
  parameter int AW           = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           advance,
  output logic [AW-1:0]                  addr,
  output mp2_pkg::win_flags_t            flags
);
  import mp2_pkg::*;

  localparam int CNW = $clog2(MAX_CHANNELS + 1);
  localparam int CCW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int WNW = $clog2(MAX_WIDTH + 1);
  localparam int WCW = $clog2(MAX_WIDTH);
  localparam int HNW = $clog2(MAX_HEIGHT + 1);
  localparam int HCW = $clog2(MAX_HEIGHT);

  logic [CH_REG_W-1:0] channels;
  logic [W_REG_W-1:0]  width;
  logic [H_REG_W-1:0]  height;

  logic [CCW-1:0] ch_cnt;
  logic [WCW-1:0] col_cnt;
  logic [HCW-1:0] row_cnt;
  logic [AW-1:0]  pair_base;

  logic [31:0]    ch_w, w_w, h_w;
  logic [CNW-1:0] ch_n;
  logic [WNW-1:0] w_n, w_used_last;
  logic [HNW-1:0] h_n, h_used_last;
  logic           last_ch, last_col, last_row, restart;

  // Clamp registers to their legal ranges
  always_comb begin
    ch_w = 32'(channels);
    w_w  = 32'(width);
    h_w  = 32'(height);
    if (ch_w < 32'd1) begin
      ch_n = CNW'(1);
    end else if (ch_w > 32'(MAX_CHANNELS)) begin
      ch_n = CNW'(MAX_CHANNELS);
    end else begin
      ch_n = CNW'(ch_w);
    end
    if (w_w < 32'd2) begin
      w_n = WNW'(2);
    end else if (w_w > 32'(MAX_WIDTH)) begin
      w_n = WNW'(MAX_WIDTH);
    end else begin
      w_n = WNW'(w_w);
    end
    if (h_w < 32'd2) begin
      h_n = HNW'(2);
    end else if (h_w > 32'(MAX_HEIGHT)) begin
      h_n = HNW'(MAX_HEIGHT);
    end else begin
      h_n = HNW'(h_w);
    end
  end

  assign w_used_last = (w_n & ~WNW'(1)) - WNW'(1);
  assign h_used_last = (h_n & ~HNW'(1)) - HNW'(1);

  assign last_ch  = (CNW'(ch_cnt) == ch_n - CNW'(1));
  assign last_col = (WNW'(col_cnt) == w_n - WNW'(1));
  assign last_row = (HNW'(row_cnt) == h_n - HNW'(1));

  assign addr = pair_base + AW'(ch_cnt);

  always_comb begin
    // a trailing odd column or row takes no part in any window
    flags.active = !(last_col && w_n[0]) && !(last_row && h_n[0]);
    flags.first  = !col_cnt[0] && !row_cnt[0];
    flags.emit   = col_cnt[0] && row_cnt[0];
    flags.fin    = col_cnt[0] && row_cnt[0] && last_ch
                   && (WNW'(col_cnt) == w_used_last)
                   && (HNW'(row_cnt) == h_used_last);
  end

  assign restart = cfg_write && (cfg_index == REG_CHANNELS || cfg_index == REG_WIDTH
                                 || cfg_index == REG_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      channels <= CHANNELS_RST;
      width    <= WIDTH_RST;
      height   <= HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNELS: channels <= cfg_data[CH_REG_W-1:0];
        REG_WIDTH:    width    <= cfg_data[W_REG_W-1:0];
        REG_HEIGHT:   height   <= cfg_data[H_REG_W-1:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      ch_cnt    <= '0;
      col_cnt   <= '0;
      row_cnt   <= '0;
      pair_base <= '0;
    end else if (advance) begin
      if (!last_ch) begin
        ch_cnt <= ch_cnt + CCW'(1);
      end else begin
        ch_cnt <= '0;
        if (last_col) begin
          col_cnt   <= '0;
          pair_base <= '0;
          row_cnt   <= last_row ? '0 : row_cnt + HCW'(1);
        end else begin
          col_cnt <= col_cnt + WCW'(1);
          // leaving an odd column: step to the next window pair
          if (col_cnt[0]) begin
            pair_base <= pair_base + AW'(ch_n);
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

/* src/mp2_outq.sv */
// Two-entry output queue that decouples the result beat from the pooling pipeline.
`timescale 1ns / 1ps
`default_nettype none
module mp2_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  mp2_pkg::result_t din,
  output logic             room,
  output logic             out_valid,
  input  logic             out_stall,
  output mp2_pkg::result_t head
);
  import mp2_pkg::*;

  logic [1:0] cnt, cnt_next;
  result_t    e0, e1;
  logic       pop;

  assign out_valid = (cnt != 2'd0);
  assign head      = e0;
  assign pop       = out_valid && !out_stall;
  assign cnt_next  = cnt + 2'(push) - 2'(pop);
  // room for one more beat arriving in the next cycle
  assign room      = (cnt_next < 2'd2);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else begin
      cnt <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && push) begin
      if (cnt == 2'd1) begin
        e0 <= din;
      end else begin
        e0 <= e1;
        e1 <= din;
      end
    end else if (pop) begin
      e0 <= e1;
    end else if (push) begin
      if (cnt == 2'd0) begin
        e0 <= din;
      end else begin
        e1 <= din;
      end
    end
  end

endmodule
`default_nettype wire

/* src/max_pool_2x2_hwc.sv */
// A pooled value passes through stage s1 and the output queue before it is offered.
// Throughput: one sample per cycle while the queue has room; the line store is read at
// acceptance and written back the next cycle, with forwarding when consecutive samples hit
// the same entry. Reset: configuration returns to 32 channels, 64 x 64, position counters
// to frame start; the line store is not cleared (each window's first sample overwrites it).
`timescale 1ns / 1ps
`default_nettype none
module max_pool_2x2_hwc #(
  parameter int MAX_CHANNELS = mp2_pkg::DEF_MAX_CHANNELS,
  parameter int MAX_WIDTH    = mp2_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = mp2_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [mp2_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [mp2_pkg::SAMPLE_W-1:0] pooled,
  output logic                                last,
  input  logic                                cfg_write,
  input  logic [mp2_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [mp2_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import mp2_pkg::*;

  localparam int STORE_DEPTH = (MAX_WIDTH / 2) * MAX_CHANNELS;
  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                       in_acc, room;
  logic [AW-1:0]              addr;
  win_flags_t                 flags;

  logic                       s1_valid;
  logic [AW-1:0]              s1_addr;
  logic signed [SAMPLE_W-1:0] s1_sample;
  win_flags_t                 s1_flags;
  logic                       fwd;
  logic signed [SAMPLE_W-1:0] fwd_val;

  logic [SAMPLE_W-1:0]        rd_data;
  logic signed [SAMPLE_W-1:0] old_max, s1_new;
  logic                       s1_write, s1_push;
  result_t                    res_in, res_head;

  assign in_stall = !room;
  assign in_acc   = in_valid && room;

  mp2_ctr #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .AW           (AW)
  ) u_ctr (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (in_acc),
    .addr      (addr),
    .flags     (flags)
  );

  mp2_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (s1_write),
    .wr_addr (s1_addr),
    .wr_data (s1_new),
    .rd_en   (in_acc),
    .rd_addr (addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_addr   <= addr;
      s1_sample <= sample;
      s1_flags  <= flags;
      // the entry being written back this cycle is not yet in the read data
      fwd       <= s1_write && (s1_addr == addr);
      fwd_val   <= s1_new;
    end
  end

  always_comb begin
    old_max = fwd ? fwd_val : $signed(rd_data);
    if (s1_flags.first || (s1_sample > old_max)) begin
      s1_new = s1_sample;
    end else begin
      s1_new = old_max;
    end
  end

  assign s1_write = s1_valid && s1_flags.active;
  assign s1_push  = s1_write && s1_flags.emit;

  assign res_in.pooled = s1_new;
  assign res_in.last   = s1_flags.fin;

  mp2_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_push),
    .din       (res_in),
    .room      (room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .head      (res_head)
  );

  assign pooled = res_head.pooled;
  assign last   = res_head.last;

endmodule
`default_nettype wire

/* bench/tb_max_pool_2x2_hwc.sv */
// Self-checking bench for the streaming 2x2 stride-2 max pooling block.
`timescale 1ns / 1ps
module tb_max_pool_2x2_hwc;
  import mp2_pkg::*;

  localparam int STORE_DEPTH = (DEF_MAX_WIDTH / 2) * DEF_MAX_CHANNELS;
  localparam int DRAIN_LIMIT = 4000;
  localparam int SHOW_LIMIT  = 10;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_stall;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                       out_valid;
  logic                       out_stall = 1'b0;
  logic signed [SAMPLE_W-1:0] pooled;
  logic                       last;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data = '0;

  max_pool_2x2_hwc dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pooled    (pooled),
    .last      (last),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: raw register values, frame position, running window maxima
  logic [CH_REG_W-1:0]        chan_reg;
  logic [W_REG_W-1:0]         wid_reg;
  logic [H_REG_W-1:0]         hgt_reg;
  int                         col_pos;
  int                         row_pos;
  int                         chan_pos;
  logic signed [SAMPLE_W-1:0] window_max [0:STORE_DEPTH-1];
  result_t                    pooled_q [$];

  int  mismatches = 0;
  bit  gaps_on = 1'b1;
  bit  stalls_on = 1'b1;
  int  stall_left = 0;

  function automatic int clamp_to(int v, int lo, int hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int frame_samples();
    return clamp_to(chan_reg, 1, DEF_MAX_CHANNELS) * clamp_to(wid_reg, 2, DEF_MAX_WIDTH) *
           clamp_to(hgt_reg, 2, DEF_MAX_HEIGHT);
  endfunction

  function automatic void restart_frame();
    col_pos = 0;
    row_pos = 0;
    chan_pos = 0;
  endfunction

  function automatic void note_mismatch(string what);
    mismatches++;
    if (mismatches <= SHOW_LIMIT) $display("[%0t] %s", $realtime, what);
  endfunction

  // Advance the window maxima by one accepted sample; queue a pooled value on a
  // bottom-right sample
  function automatic void pool_sample(logic signed [SAMPLE_W-1:0] s);
    int      ch_n;
    int      w_n;
    int      h_n;
    int      w_used;
    int      h_used;
    int      idx;
    result_t r;
    ch_n   = clamp_to(chan_reg, 1, DEF_MAX_CHANNELS);
    w_n    = clamp_to(wid_reg, 2, DEF_MAX_WIDTH);
    h_n    = clamp_to(hgt_reg, 2, DEF_MAX_HEIGHT);
    w_used = w_n & ~1;
    h_used = h_n & ~1;
    if (chan_pos >= ch_n || col_pos >= w_n || row_pos >= h_n) restart_frame();
    if (col_pos < w_used && row_pos < h_used) begin
      idx = (col_pos / 2) * ch_n + chan_pos;
      if (col_pos % 2 == 0 && row_pos % 2 == 0) window_max[idx] = s;
      else if (s > window_max[idx]) window_max[idx] = s;
      if (col_pos % 2 == 1 && row_pos % 2 == 1) begin
        r.pooled = window_max[idx];
        r.last   = (row_pos == h_used - 1) && (col_pos == w_used - 1) && (chan_pos == ch_n - 1);
        pooled_q.push_back(r);
      end
    end
    chan_pos++;
    if (chan_pos >= ch_n) begin
      chan_pos = 0;
      col_pos++;
      if (col_pos >= w_n) begin
        col_pos = 0;
        row_pos++;
        if (row_pos >= h_n) row_pos = 0;
      end
    end
  endfunction

  function automatic void check_pooled();
    result_t want;
    if (pooled_q.size() == 0) begin
      note_mismatch($sformatf("unexpected beat: pooled=%0d last=%0b", pooled, last));
      return;
    end
    want = pooled_q.pop_front();
    if (pooled !== want.pooled)
      note_mismatch($sformatf("pooled: expected %0d, got %0d", want.pooled, pooled));
    if (last !== want.last)
      note_mismatch($sformatf("last: expected %0b, got %0b", want.last, last));
  endfunction

  // Input acceptance is predicted before the output side is checked
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_stall === 1'b0) pool_sample(sample);
      if (out_valid === 1'b1 && !out_stall) check_pooled();
    end
  end

  // Receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (stalls_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 13) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample   <= v;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
  endtask

  // Hold the sender until every pooled value is out, then let the pipeline empty
  task automatic settle_pipeline();
    int waited;
    waited = 0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pooled_q.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (pooled_q.size() != 0) begin
      note_mismatch($sformatf("%0d pooled values never arrived", pooled_q.size()));
      pooled_q.delete();
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_CHANNELS: chan_reg = data[CH_REG_W-1:0];
      REG_WIDTH:    wid_reg  = data[W_REG_W-1:0];
      REG_HEIGHT:   hgt_reg  = data[H_REG_W-1:0];
      default: ;
    endcase
    if (idx == REG_CHANNELS || idx == REG_WIDTH || idx == REG_HEIGHT) restart_frame();
    cfg_write <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_shape(input int ch, input int w, input int h);
    write_reg(REG_CHANNELS, CFG_DATA_W'(ch));
    write_reg(REG_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_HEIGHT, CFG_DATA_W'(h));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 9))
      0, 1: return SAMPLE_W'($urandom_range(0, 8) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: return 16'sh8000;
          1: return 16'sh7fff;
          2: return 16'sh0000;
          default: return 16'shffff;
        endcase
      end
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Window maxima at the sample extremes: all equal, max last, max first
  task automatic test_window_extremes();
    logic signed [SAMPLE_W-1:0] vals [0:11];
    vals = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
             16'sh0100, 16'shffff, 16'sh8000, 16'sh7fff,
             16'shffff, 16'sh8001, 16'sh8000, 16'shfffe};
    settle_pipeline();
    set_shape(1, 2, 2);
    foreach (vals[i]) send_sample(vals[i]);
    settle_pipeline();
  endtask

  // A write part-way through a frame sends the block back to the frame start
  task automatic test_restart_on_write();
    repeat (5) send_sample(pick_sample());
    settle_pipeline();
    set_shape(1, 2, 2);
    repeat (3) send_sample(pick_sample());
    settle_pipeline();
    write_reg(REG_HEIGHT, 9'd2);
    repeat (4) send_sample(pick_sample());
    settle_pipeline();
  endtask

  // Odd width and height: trailing column and row take no part in any window
  task automatic test_trailing_edges();
    set_shape(1, 3, 3);
    repeat (9) send_sample(pick_sample());
    settle_pipeline();
  endtask

  // Out-of-range register values clamp; the widest and tallest frames
  task automatic test_clamped_extremes();
    set_shape(0, 1, 0);
    repeat (4) send_sample(pick_sample());
    settle_pipeline();
    set_shape(0, 511, 1);
    repeat (512) send_sample(pick_sample());
    settle_pipeline();
    set_shape(0, 0, 511);
    repeat (512) send_sample(pick_sample());
    settle_pipeline();
  endtask

  task automatic test_random_frames(input int target, input int quiet_from);
    int sent;
    int phase;
    int flen;
    int n;
    int pause_at;
    sent  = 0;
    phase = 0;
    while (sent < target) begin
      case ($urandom_range(0, 9))
        0: set_shape($urandom_range(16, 64), $urandom_range(2, 3), $urandom_range(2, 3));
        1: set_shape($urandom_range(0, 1) ? 0 : $urandom_range(65, 127),
                     $urandom_range(0, 1), $urandom_range(0, 1));
        default: set_shape($urandom_range(1, 4), $urandom_range(2, 9), $urandom_range(2, 7));
      endcase
      flen = frame_samples();
      if ($urandom_range(0, 9) < 7) n = (flen > 100) ? flen : flen * $urandom_range(1, 2);
      else n = $urandom_range(1, 2 * flen);
      // stop a noisy phase where the quiet part begins, and the run at its target
      if (sent < quiet_from && n > quiet_from - sent) n = quiet_from - sent;
      else if (n > target - sent) n = target - sent;
      if (sent >= quiet_from) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end else begin
        gaps_on   = $urandom_range(0, 3) != 0;
        stalls_on = $urandom_range(0, 3) != 0;
      end
      pause_at = (phase == 0 || $urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
      for (int i = 0; i < n; i++) begin
        if (i == pause_at) settle_pipeline();
        send_sample(pick_sample());
      end
      sent += n;
      phase++;
      settle_pipeline();
    end
  endtask

  initial begin
    chan_reg = CHANNELS_RST;
    wid_reg  = WIDTH_RST;
    hgt_reg  = HEIGHT_RST;
    restart_frame();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_restart_on_write();
    test_window_extremes();
    test_trailing_edges();
    test_clamped_extremes();
    test_random_frames(60, 30);
    settle_pipeline();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

/* max_pool_2x2_hwc.f */
src/mp2_pkg.sv
src/mp2_ram.sv
src/mp2_ctr.sv
src/mp2_outq.sv
src/max_pool_2x2_hwc.sv
bench/tb_max_pool_2x2_hwc.sv
